FILE: sv/edge_timed_uart_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge-timed UART receiver
// Implication templates on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_TIMED_UART_RECEIVER_ASSERT_SVH
`define EDGE_TIMED_UART_RECEIVER_ASSERT_SVH

// same-cycle implication
`define ETUR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETUR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/etur_pkg.sv
// ----------------------------------------------------------------------------
// etur_pkg
// Shared types and constants of the edge-timed UART receiver.
// ----------------------------------------------------------------------------
package etur_pkg;

    localparam int QUEUE_DEPTH_DEF   = 1024;
    localparam int TICKS_PER_BIT_DEF = 8;
    localparam int TIME_WIDTH_DEF    = 16;

    localparam int BYTE_W    = 8;
    localparam int AVAIL_W   = 10;
    localparam int DROP_W    = 16;
    localparam int M_FIELD_W = BYTE_W + AVAIL_W + DROP_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    // bit position, offset by two: wait for idle, start bit, data bits, byte done
    localparam logic [3:0] POS_WAIT_IDLE = 4'd0;
    localparam logic [3:0] POS_START     = 4'd1;
    localparam logic [3:0] POS_DONE      = 4'd10;

    localparam int MAX_GAP_BITS = 10;

    typedef enum logic [1:0] {
        OP_LINE_EVENT = 2'd0,
        OP_POP        = 2'd1,
        OP_PEEK       = 2'd2,
        OP_FLUSH      = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_BITS,
        ST_PUSH,
        ST_FINISH,
        ST_READ,
        ST_FETCH,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
        logic rd;
    } queue_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

FILE: sv/etur_queue.sv
// ----------------------------------------------------------------------------
// etur_queue
// Receive ring queue: byte memory with registered read, pointers and fill level.
// ----------------------------------------------------------------------------
module etur_queue #(
    parameter int QUEUE_DEPTH = etur_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  etur_pkg::queue_cmd_t         cmd,
    input  logic [etur_pkg::BYTE_W-1:0]  wr_byte,
    output logic [etur_pkg::BYTE_W-1:0]  rd_byte,
    output logic [PTR_W-1:0]             count,
    output etur_pkg::queue_stat_t        stat
);

    logic [etur_pkg::BYTE_W-1:0] mem [QUEUE_DEPTH];
    logic [etur_pkg::BYTE_W-1:0] rd_byte_reg;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]              diff;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd.flush) begin
            wr_ptr_next = rd_ptr_reg;
        end else if (cmd.push) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (cmd.pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
    end

    always_comb begin
        diff = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        if (diff[PTR_W]) begin
            diff = diff + (PTR_W + 1)'(QUEUE_DEPTH);
        end
        count      = diff[PTR_W-1:0];
        stat.empty = (count == '0);
        stat.full  = ({1'b0, count} >= (PTR_W + 1)'(QUEUE_DEPTH - 2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_ptr_reg] <= wr_byte;
        end
        if (cmd.rd) begin
            rd_byte_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

FILE: sv/edge_timed_uart_receiver.sv
// ----------------------------------------------------------------------------
// edge_timed_uart_receiver
// 8N1 UART receiver driven by timestamped line edges, with a receive queue.
// ----------------------------------------------------------------------------
// Each input transfer is a line edge (level and tick timestamp) or a queue
// request (pop, peek, flush); each yields exactly one result transfer with the
// byte read, its valid flag, the queue fill level and the saturating overflow
// count. The block handles one transfer at a time. A line edge passes from
// acceptance to result through the gap measurement, the bit sequencer, which
// consumes one bit time per step (at most nine: the start bit and eight data
// bits), a state either to leave the sequencer or, when a byte completes, for
// the queue write, and the states that commit and present the result. Pop and
// peek pass through a read state and a fetch state, as the queue memory has a
// registered read; flush goes straight to the result. A result held by the
// sink stalls only the next result. The queue holds QUEUE_DEPTH-2 bytes and
// needs no clearing after reset.
// ----------------------------------------------------------------------------
module edge_timed_uart_receiver #(
    parameter int QUEUE_DEPTH   = etur_pkg::QUEUE_DEPTH_DEF,
    parameter int TICKS_PER_BIT = etur_pkg::TICKS_PER_BIT_DEF,
    parameter int TIME_WIDTH    = etur_pkg::TIME_WIDTH_DEF,
    localparam int S_TDATA_W    = ((1 + TIME_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] line_level, [TIME_WIDTH:1] timestamp, rest zero
    input  logic [S_TDATA_W-1:0]           s_tdata,
    // [1:0] opcode
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] data_byte, [17:8] bytes_available, [33:18] overflow_total, rest zero
    output logic [etur_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] data_valid
    output logic                           m_tuser
);

    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ROUND      = TICKS_PER_BIT / 4;
    localparam int GAP_TICKS  = (etur_pkg::MAX_GAP_BITS + 1) * TICKS_PER_BIT;
    localparam int CAP_TICKS  = etur_pkg::MAX_GAP_BITS * TICKS_PER_BIT;
    localparam int GAP_W      = $clog2(GAP_TICKS + 1);
    localparam int REM_W      = (TIME_WIDTH + 1 > GAP_W) ? TIME_WIDTH + 1 : GAP_W;

    etur_pkg::seq_state_t state_reg, state_next;
    etur_pkg::opcode_t    op_reg, op_next;
    logic                 level_reg, level_next;
    logic [TIME_WIDTH-1:0] ts_reg, ts_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [3:0]           pos_reg, pos_next;
    logic [7:0]           shift_reg, shift_next;
    logic                 prev_level_reg, prev_level_next;
    logic [TIME_WIDTH-1:0] prev_time_reg, prev_time_next;
    logic [etur_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic [7:0]           data_reg, data_next;
    logic                 valid_reg, valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [etur_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    etur_pkg::queue_cmd_t  q_cmd;
    etur_pkg::queue_stat_t q_stat;
    logic [7:0]            q_rd_byte;
    logic [PTR_W-1:0]      q_count;

    etur_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (q_cmd),
        .wr_byte (shift_reg),
        .rd_byte (q_rd_byte),
        .count   (q_count),
        .stat    (q_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= etur_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic [TIME_WIDTH-1:0] dt;
        logic [REM_W-1:0]      rem0;
        logic [3:0]            pos_tmp;

        state_next      = state_reg;
        op_next         = op_reg;
        level_next      = level_reg;
        ts_next         = ts_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        prev_level_next = prev_level_reg;
        prev_time_next  = prev_time_reg;
        drop_next       = drop_reg;
        data_next       = data_reg;
        valid_next      = valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        q_cmd           = '0;
        dt              = ts_reg - prev_time_reg;
        rem0            = REM_W'(dt) + REM_W'(ROUND);
        pos_tmp         = pos_reg;

        case (state_reg)
            etur_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = etur_pkg::opcode_t'(s_tuser);
                    level_next = s_tdata[0];
                    ts_next    = s_tdata[TIME_WIDTH:1];
                    data_next  = '0;
                    valid_next = 1'b0;
                    case (etur_pkg::opcode_t'(s_tuser))
                        etur_pkg::OP_LINE_EVENT: state_next = etur_pkg::ST_GAP;
                        etur_pkg::OP_POP,
                        etur_pkg::OP_PEEK:       state_next = etur_pkg::ST_READ;
                        etur_pkg::OP_FLUSH: begin
                            q_cmd.flush = 1'b1;
                            state_next  = etur_pkg::ST_RESULT;
                        end
                        default:                 state_next = etur_pkg::ST_RESULT;
                    endcase
                end
            end
            etur_pkg::ST_GAP: begin
                if (rem0 >= REM_W'(GAP_TICKS)) begin
                    rem_next = REM_W'(CAP_TICKS);
                    pos_tmp  = etur_pkg::POS_WAIT_IDLE;
                end else begin
                    rem_next = rem0;
                end
                if (pos_tmp == etur_pkg::POS_WAIT_IDLE && !prev_level_reg) begin
                    pos_tmp    = etur_pkg::POS_START;
                    shift_next = '0;
                end
                pos_next   = pos_tmp;
                state_next = etur_pkg::ST_BITS;
            end
            etur_pkg::ST_BITS: begin
                if (pos_reg == etur_pkg::POS_WAIT_IDLE ||
                    rem_reg < REM_W'(TICKS_PER_BIT)) begin
                    state_next = etur_pkg::ST_FINISH;
                end else begin
                    if (pos_reg != etur_pkg::POS_START) begin
                        shift_next = {prev_level_reg, shift_reg[7:1]};
                    end
                    pos_next = pos_reg + 4'd1;
                    rem_next = rem_reg - REM_W'(TICKS_PER_BIT);
                    if (pos_next == etur_pkg::POS_DONE) begin
                        state_next = etur_pkg::ST_PUSH;
                    end
                end
            end
            etur_pkg::ST_PUSH: begin
                if (q_stat.full) begin
                    if (drop_reg != etur_pkg::DROP_MAX) begin
                        drop_next = drop_reg + etur_pkg::DROP_W'(1);
                    end
                end else begin
                    q_cmd.push = 1'b1;
                end
                pos_next   = etur_pkg::POS_WAIT_IDLE;
                state_next = etur_pkg::ST_FINISH;
            end
            etur_pkg::ST_FINISH: begin
                prev_level_next = level_reg;
                prev_time_next  = ts_reg;
                state_next      = etur_pkg::ST_RESULT;
            end
            etur_pkg::ST_READ: begin
                q_cmd.rd   = 1'b1;
                state_next = etur_pkg::ST_FETCH;
            end
            etur_pkg::ST_FETCH: begin
                if (!q_stat.empty) begin
                    data_next  = q_rd_byte;
                    valid_next = 1'b1;
                    q_cmd.pop  = (op_reg == etur_pkg::OP_POP);
                end
                state_next = etur_pkg::ST_RESULT;
            end
            etur_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{etur_pkg::M_PAD_W{1'b0}}, drop_reg,
                                     etur_pkg::AVAIL_W'(q_count), data_reg};
                    m_tuser_next  = valid_reg;
                    state_next    = etur_pkg::ST_IDLE;
                end
            end
            default: state_next = etur_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= etur_pkg::POS_START;
            shift_reg      <= '0;
            prev_level_reg <= 1'b0;
            prev_time_reg  <= '0;
            drop_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            prev_level_reg <= prev_level_next;
            prev_time_reg  <= prev_time_next;
            drop_reg       <= drop_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        level_reg   <= level_next;
        ts_reg      <= ts_next;
        rem_reg     <= rem_next;
        data_reg    <= data_next;
        valid_reg   <= valid_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == etur_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/etur_checker.sv
// ----------------------------------------------------------------------------
// etur_checker
// Port-level checks of the edge-timed UART receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "edge_timed_uart_receiver_assert.svh"

module etur_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [etur_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    `ETUR_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ETUR_ASSERT_NXT(a_result_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ETUR_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0, "byte not zero without data_valid")
    `ETUR_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind edge_timed_uart_receiver etur_checker u_etur_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/edge_timed_uart_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_timed_uart_receiver_test
// Self-checking bench for the edge-timed 8N1 UART receiver and its queue.
// ----------------------------------------------------------------------------
// Line edges and queue requests go in on the slave stream; every transfer out
// is compared field by field with a cycle-free model of the receiver that is
// updated at each accepted input. A short table covers empty-queue requests,
// rounding and idle-gap limits and timestamp wrap; random traffic follows with
// jittered frames, broken frames, line noise and queue requests, under three
// idling mixes.
// ----------------------------------------------------------------------------
module edge_timed_uart_receiver_test;

    localparam int QDEPTH = etur_pkg::QUEUE_DEPTH_DEF;
    localparam int TICKS  = etur_pkg::TICKS_PER_BIT_DEF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic [9:0]  avail;
        logic [15:0] drops;
    } rx_result_t;

    typedef struct {
        etur_pkg::opcode_t op;
        logic              lvl;
        logic [15:0]       stamp;
        bit                typed;
        rx_result_t        want;
    } dir_row_t;

    localparam rx_result_t NO_DATA = '0;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata   = '0;
    logic [1:0]                     s_tuser   = etur_pkg::OP_POP;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [etur_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    bit                   row_typed = 1'b0;
    rx_result_t           row_want  = '0;

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   items_sent    = 0;
    int                   results_seen  = 0;
    int                   mismatches    = 0;
    int                   bytes_framed  = 0;
    int                   peak_fill     = 0;

    // receiver model state
    logic [7:0]           rx_mem [0:QDEPTH-1];
    int                   rx_wr = 0;
    int                   rx_rd = 0;
    logic [7:0]           rx_shift = '0;
    int                   rx_pos = -1;
    logic                 rx_last_level = 1'b0;
    logic [15:0]          rx_last_stamp = '0;
    logic [15:0]          rx_drops = '0;

    rx_result_t           pending_results [$];

    // bench view of the line
    logic [15:0]          line_ref = '0;
    logic                 line_lvl = 1'b0;

    dir_row_t dir_rows [0:24] = '{
        '{etur_pkg::OP_POP,        1'b0, 16'h0000, 1'b1, NO_DATA},
        '{etur_pkg::OP_PEEK,       1'b0, 16'h0000, 1'b1, NO_DATA},
        '{etur_pkg::OP_FLUSH,      1'b0, 16'h0000, 1'b1, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0000, 1'b1, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'h00C8, 1'b1, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0110, 1'b0, NO_DATA},
        '{etur_pkg::OP_PEEK,       1'b0, 16'h0000, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'hFFF0, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'hFFF8, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'h0030, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0038, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'hFFFF, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0007, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'h004F, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0053, 1'b0, NO_DATA},
        '{etur_pkg::OP_POP,        1'b0, 16'h0000, 1'b0, NO_DATA},
        '{etur_pkg::OP_POP,        1'b1, 16'hFFFF, 1'b0, NO_DATA},
        '{etur_pkg::OP_PEEK,       1'b0, 16'h0000, 1'b0, NO_DATA},
        '{etur_pkg::OP_FLUSH,      1'b1, 16'hFFFF, 1'b1, NO_DATA},
        '{etur_pkg::OP_POP,        1'b0, 16'h0000, 1'b1, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'h0100, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0155, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b0, 16'h01AB, 1'b0, NO_DATA},
        '{etur_pkg::OP_LINE_EVENT, 1'b1, 16'h0201, 1'b0, NO_DATA},
        '{etur_pkg::OP_PEEK,       1'b0, 16'h0000, 1'b0, NO_DATA}
    };

    edge_timed_uart_receiver u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int queue_fill();
        return (rx_wr - rx_rd + QDEPTH) % QDEPTH;
    endfunction

    function automatic rx_result_t rx_predict(etur_pkg::opcode_t op, logic lvl,
                                              logic [15:0] stamp);
        rx_result_t  r;
        logic [15:0] gap;
        int          nbits;
        int          i;
        r = '0;
        case (op)
            etur_pkg::OP_LINE_EVENT: begin
                gap   = stamp - rx_last_stamp;
                nbits = (int'(gap) + TICKS / 4) / TICKS;
                if (nbits > etur_pkg::MAX_GAP_BITS) begin
                    nbits  = etur_pkg::MAX_GAP_BITS;
                    rx_pos = -2;
                end
                if (rx_pos == -2 && rx_last_level == 1'b0) begin
                    rx_pos   = -1;
                    rx_shift = '0;
                end
                if (rx_pos > -2) begin
                    for (i = 0; i < nbits; i++) begin
                        if (rx_pos >= 0)
                            rx_shift = {rx_last_level, rx_shift[7:1]};
                        rx_pos++;
                        if (rx_pos >= 8) begin
                            if (queue_fill() >= QDEPTH - 2) begin
                                if (rx_drops != etur_pkg::DROP_MAX)
                                    rx_drops++;
                            end else begin
                                rx_mem[rx_wr] = rx_shift;
                                rx_wr         = (rx_wr + 1) % QDEPTH;
                                bytes_framed++;
                            end
                            rx_pos = -2;
                            break;
                        end
                    end
                end
                rx_last_level = lvl;
                rx_last_stamp = stamp;
            end
            etur_pkg::OP_POP, etur_pkg::OP_PEEK: begin
                if (queue_fill() != 0) begin
                    r.data_byte  = rx_mem[rx_rd];
                    r.data_valid = 1'b1;
                    if (op == etur_pkg::OP_POP)
                        rx_rd = (rx_rd + 1) % QDEPTH;
                end
            end
            default: rx_wr = rx_rd;
        endcase
        if (queue_fill() > peak_fill)
            peak_fill = queue_fill();
        r.avail = 10'(queue_fill());
        r.drops = rx_drops;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : monitor
        rx_result_t want;
        rx_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = rx_predict(etur_pkg::opcode_t'(s_tuser), s_tdata[0], s_tdata[16:1]);
                if (row_typed)
                    want = row_want;
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.data_byte  = m_tdata[7:0];
                got.data_valid = m_tuser;
                got.avail      = m_tdata[17:8];
                got.drops      = m_tdata[33:18];
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("transfer with none expected", got.data_byte, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.data_byte !== want.data_byte)
                        report_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.data_valid !== want.data_valid)
                        report_mismatch("data_valid", got.data_valid, want.data_valid);
                    if (got.avail !== want.avail)
                        report_mismatch("bytes_available", got.avail, want.avail);
                    if (got.drops !== want.drops)
                        report_mismatch("overflow_total", got.drops, want.drops);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input etur_pkg::opcode_t op, input logic lvl,
                             input logic [15:0] stamp,
                             input bit typed = 1'b0, input rx_result_t want = '0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {7'b0, stamp, lvl};
        s_tuser   <= op;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge aclk);
    endtask

    // one 8N1 frame, edges jittered by up to two ticks; may be cut short
    task automatic send_frame(logic [7:0] value, int stop_at);
        logic [9:0] bits;
        logic       lvl_prev;
        int         i;
        bits = {1'b1, value, 1'b0};
        if (line_lvl == 1'b0) begin
            line_ref = line_ref + 16'(TICKS * $urandom_range(1, 12));
            send_item(etur_pkg::OP_LINE_EVENT, 1'b1, line_ref + 16'($urandom_range(0, 2)));
            line_lvl = 1'b1;
        end
        if ($urandom_range(0, 99) < 70)
            line_ref = line_ref + 16'(TICKS * $urandom_range(0, 2));
        else
            line_ref = line_ref + 16'(TICKS * $urandom_range(3, 30));
        lvl_prev = 1'b1;
        for (i = 0; i < stop_at; i++) begin
            if (bits[i] != lvl_prev) begin
                send_item(etur_pkg::OP_LINE_EVENT, bits[i],
                          line_ref + 16'(TICKS * i + $urandom_range(0, 2)));
                lvl_prev = bits[i];
                if ($urandom_range(0, 99) < 5)
                    send_item(etur_pkg::opcode_t'($urandom_range(etur_pkg::OP_POP,
                                                                  etur_pkg::OP_PEEK)),
                              1'b0, 16'h0000);
            end
        end
        line_lvl = lvl_prev;
        line_ref = line_ref + 16'(TICKS * stop_at);
    endtask

    task automatic run_traffic(int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_frame(8'($urandom), ($urandom_range(0, 99) < 10) ?
                           $urandom_range(1, 9) : 10);
            end else if (pick < 75) begin
                send_item(etur_pkg::OP_POP, 1'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                send_item(etur_pkg::OP_PEEK, 1'($urandom), 16'($urandom));
            end else if (pick < 88) begin
                send_item(etur_pkg::OP_FLUSH, 1'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                line_lvl = 1'($urandom);
                line_ref = line_ref + 16'($urandom_range(0, 100));
                send_item(etur_pkg::OP_LINE_EVENT, line_lvl, line_ref);
            end else begin
                line_lvl = 1'($urandom);
                line_ref = 16'($urandom);
                send_item(etur_pkg::OP_LINE_EVENT, line_lvl, line_ref);
            end
        end
    endtask

    initial begin
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 87;
        for (n = 0; n < 25; n++)
            send_item(dir_rows[n].op, dir_rows[n].lvl, dir_rows[n].stamp,
                      dir_rows[n].typed, dir_rows[n].want);
        line_ref = 16'h0201;
        line_lvl = 1'b1;
        run_traffic(300);
        wait_drained();

        send_idle_pct = 87;
        recv_idle_pct = 13;
        run_traffic(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(300);

        wait_drained();
        repeat (32) @(posedge aclk);

        $display("Run covered %0d input transfers and %0d results: directed limits,",
                 items_sent, results_seen);
        $display("framed and broken bytes, noise, queue requests; %0d bytes, peak fill %0d",
                 bytes_framed, peak_fill);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
